FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the cosine item memory.
// Standalone header; the bodies collapse to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CIM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CIM_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CIM_ASSERT(lbl, clk, rst, prop, msg)
`define CIM_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/cimlc_pkg.sv
// Shared types and constants of the cosine item memory lookup core.
// No dependencies.
package cimlc_pkg;

   typedef struct packed {
      logic               opcode;
      logic signed [15:0] element_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         item_index;
      logic signed [15:0] similarity;
      logic [4:0]         items_held;
   } rsp_type;

   localparam logic [1:0] ST_STORED = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_MATCH  = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int          VLEN_W     = 11;
   localparam logic [10:0] VLEN_RESET = 11'd1024;

   // fraction bits of the Q1.15 quotient
   localparam int DIV_STEPS = 15;

   typedef enum logic [3:0] {
      S_IDLE, S_NORM, S_RD, S_MUL, S_ACC, S_END, S_CRD, S_CST, S_CWT, S_RES
   } ctl_state_type;

   typedef enum logic [2:0] {
      C_IDLE, C_MUL, C_SQRT, C_CHK, C_DIV, C_DONE
   } cos_state_type;

endpackage

FILE: rtl/cimlc_cosine.sv
// Multi-cycle cosine unit: shift-add product of norms, digit-by-digit square
// root, then restoring division to a Q1.15 similarity. Uses cimlc_pkg.
module cimlc_cosine #(
   parameter int ACC_W = 42
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dot,
   input  logic        [ACC_W-1:0] na,
   input  logic        [ACC_W-1:0] nq,
   output logic                    done,
   output logic signed [15:0]      sim
);

   localparam int PW = 2 * ACC_W;
   localparam int RW = ACC_W + 2;
   localparam int CW = $clog2(ACC_W);

   cimlc_pkg::cos_state_type state_ff, state_in;
   logic [ACC_W-1:0] a_ff, a_in, b_ff, b_in, root_ff, root_in, mag_ff, mag_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [15:0]      q_ff, q_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [RW+1:0]    sq_tmp, sq_trial;
   logic [RW:0]      div_tmp;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cimlc_pkg::C_IDLE: begin
            if (start) begin
               state_in = (na == '0 || nq == '0) ? cimlc_pkg::C_DONE : cimlc_pkg::C_MUL;
            end
         end
         cimlc_pkg::C_MUL: begin
            if (cnt_ff == CW'(ACC_W - 1)) state_in = cimlc_pkg::C_SQRT;
         end
         cimlc_pkg::C_SQRT: begin
            if (cnt_ff == CW'(ACC_W - 1)) state_in = cimlc_pkg::C_CHK;
         end
         cimlc_pkg::C_CHK: begin
            state_in = (mag_ff >= root_ff) ? cimlc_pkg::C_DONE : cimlc_pkg::C_DIV;
         end
         cimlc_pkg::C_DIV: begin
            if (cnt_ff == CW'(cimlc_pkg::DIV_STEPS - 1)) state_in = cimlc_pkg::C_DONE;
         end
         cimlc_pkg::C_DONE: state_in = cimlc_pkg::C_IDLE;
         default:           state_in = cimlc_pkg::C_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      sq_tmp  = {rem_ff, p_ff[PW-1:PW-2]};
      sq_trial = (RW + 2)'({root_ff, 2'b01});
      div_tmp = {rem_ff, 1'b0};
      case (state_ff)
         cimlc_pkg::C_IDLE: begin
            if (start) begin
               a_in   = na;
               b_in   = nq;
               p_in   = '0;
               cnt_in = '0;
               q_in   = '0;
               neg_in = dot[ACC_W-1];
               mag_in = dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
            end
         end
         cimlc_pkg::C_MUL: begin
            p_in   = {p_ff[PW-2:0], 1'b0} + (b_ff[ACC_W-1] ? PW'(a_ff) : '0);
            b_in   = {b_ff[ACC_W-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ACC_W - 1)) begin
               cnt_in  = '0;
               root_in = '0;
               rem_in  = '0;
            end
         end
         cimlc_pkg::C_SQRT: begin
            // two product bits per step
            if (sq_tmp >= sq_trial) begin
               rem_in  = RW'(sq_tmp - sq_trial);
               root_in = {root_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in  = RW'(sq_tmp);
               root_in = {root_ff[ACC_W-2:0], 1'b0};
            end
            p_in   = {p_ff[PW-3:0], 2'b00};
            cnt_in = cnt_ff + CW'(1);
         end
         cimlc_pkg::C_CHK: begin
            cnt_in = '0;
            rem_in = RW'(mag_ff);
            if (mag_ff >= root_ff) q_in = 16'h8000;
         end
         cimlc_pkg::C_DIV: begin
            if (div_tmp >= (RW + 1)'(root_ff)) begin
               rem_in = RW'(div_tmp - (RW + 1)'(root_ff));
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = RW'(div_tmp);
               q_in   = {q_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
         end
         default: begin
         end
      endcase
   end

   // outputs: sign and clamp of the quotient
   always_comb begin
      done = (state_ff == cimlc_pkg::C_DONE);
      if (neg_ff)      sim = signed'(16'(-q_ff));
      else if (q_ff[15]) sim = 16'sh7FFF;
      else             sim = signed'(q_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cimlc_pkg::C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      p_ff    <= p_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

endmodule

FILE: rtl/cosine_item_memory_lookup_core.sv
// Top level of the cosine item memory: element memory, per-slot dot and norm
// memories, control sequencer and CSR. Uses cimlc_pkg, cimlc_cosine and assert_macros.svh.
//
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  cimlc_pkg::req_type
// rsp      out        rsp_valid/rsp_ready  cimlc_pkg::rsp_type
// csr      in         APB, pready tied 1   vector_length at byte 0
//
// A store element passes the norm and end states; a query element also runs the
// read, multiply and accumulate states once per held slot, one slot per pass,
// set by the single read port of the element memory. The final query element
// then passes every held slot through the shared cosine unit (shorter on a zero
// norm or a saturated quotient) and then loads the result. Reset is synchronous;
// no clearing pass. req_ready is high only between transactions; a result waits
// in the output register and stalls only the next vector end.
`include "assert_macros.svh"
module cosine_item_memory_lookup_core #(
   parameter int CAPACITY     = 16,
   parameter int MAX_LENGTH   = 1024,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cimlc_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cimlc_pkg::rsp_type  rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [1:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int POS_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DEPTH  = CAPACITY * MAX_LENGTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = 2 * ELEMENT_BITS;
   localparam int ACC_W  = PROD_W + LEN_W;
   localparam int RAW_W  = (ELEMENT_BITS > 16) ? ELEMENT_BITS : 16;
   localparam int CMP_W  = (LEN_W > cimlc_pkg::VLEN_W) ? LEN_W : cimlc_pkg::VLEN_W;

   cimlc_pkg::ctl_state_type state_ff, state_in;

   logic [cimlc_pkg::VLEN_W-1:0] vl_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              query_ff, first_ff, last_ff;
   logic signed [ELEMENT_BITS-1:0] x_ff, x_in, rd_elem_ff;
   logic signed [PROD_W-1:0] sq_ff, prod_ff;
   logic signed [ACC_W-1:0]  nacc_ff, qnorm_ff, rd_dot_ff, rd_norm_ff, dot_new, sq_ext;
   logic signed [15:0] best_sim_ff;
   logic [SLOT_W-1:0]  best_idx_ff;
   logic               rsp_valid_ff;
   cimlc_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [ELEMENT_BITS-1:0] store_mem [DEPTH];
   logic signed [ACC_W-1:0]        dot_mem   [CAPACITY];
   logic signed [ACC_W-1:0]        norm_mem  [CAPACITY];

   logic [RAW_W-1:0]  raw;
   logic [CMP_W-1:0]  vl_ext;
   logic [LEN_W-1:0]  len_eff, pos_plus;
   logic [SLOT_W-1:0] slot_sel;
   logic [ADDR_W-1:0] addr;
   logic              accept, rsp_free, rsp_load, slot_last, has_room, held;
   logic              st_we, st_re, dot_re, dot_we, norm_we, norm_re, cos_start, cos_done;
   logic signed [15:0] cos_sim;
   logic              csr_write;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(vl_ff) : '0;

   // effective vector length and element decode
   always_comb begin
      vl_ext = CMP_W'(vl_ff);
      if (vl_ext == '0)                       len_eff = LEN_W'(1);
      else if (vl_ext > CMP_W'(MAX_LENGTH))   len_eff = LEN_W'(MAX_LENGTH);
      else                                    len_eff = LEN_W'(vl_ext);
      raw      = RAW_W'($unsigned(req_data.element_value));
      x_in     = signed'(raw[ELEMENT_BITS-1:0]);
      pos_plus = LEN_W'(pos_ff) + LEN_W'(1);
   end

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign slot_last = (CNT_W'(slot_ff) + CNT_W'(1)) == count_ff;
   assign has_room  = count_ff < CNT_W'(CAPACITY);
   assign held      = count_ff != '0;
   assign slot_sel  = (state_ff == cimlc_pkg::S_NORM) ? count_ff[SLOT_W-1:0] : slot_ff;
   assign addr      = ADDR_W'(slot_sel) * ADDR_W'(MAX_LENGTH) + ADDR_W'(pos_ff);
   assign sq_ext    = ACC_W'(sq_ff);
   assign dot_new   = (first_ff ? '0 : rd_dot_ff) + ACC_W'(prod_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cimlc_pkg::S_IDLE: if (req_valid) state_in = cimlc_pkg::S_NORM;
         cimlc_pkg::S_NORM: begin
            state_in = (query_ff && held) ? cimlc_pkg::S_RD : cimlc_pkg::S_END;
         end
         cimlc_pkg::S_RD:  state_in = cimlc_pkg::S_MUL;
         cimlc_pkg::S_MUL: state_in = cimlc_pkg::S_ACC;
         cimlc_pkg::S_ACC: state_in = slot_last ? cimlc_pkg::S_END : cimlc_pkg::S_RD;
         cimlc_pkg::S_END: begin
            if (!last_ff)              state_in = cimlc_pkg::S_IDLE;
            else if (query_ff && held) state_in = cimlc_pkg::S_CRD;
            else if (rsp_free)         state_in = cimlc_pkg::S_IDLE;
         end
         cimlc_pkg::S_CRD: state_in = cimlc_pkg::S_CST;
         cimlc_pkg::S_CST: state_in = cimlc_pkg::S_CWT;
         cimlc_pkg::S_CWT: begin
            if (cos_done) state_in = slot_last ? cimlc_pkg::S_RES : cimlc_pkg::S_CRD;
         end
         cimlc_pkg::S_RES: if (rsp_free) state_in = cimlc_pkg::S_IDLE;
         default: state_in = cimlc_pkg::S_IDLE;
      endcase
   end

   // control outputs and result word
   always_comb begin
      req_ready = (state_ff == cimlc_pkg::S_IDLE);
      st_we     = (state_ff == cimlc_pkg::S_NORM) && !query_ff && has_room;
      st_re     = (state_ff == cimlc_pkg::S_RD);
      dot_re    = (state_ff == cimlc_pkg::S_RD) || (state_ff == cimlc_pkg::S_CRD);
      dot_we    = (state_ff == cimlc_pkg::S_ACC);
      norm_re   = (state_ff == cimlc_pkg::S_CRD);
      cos_start = (state_ff == cimlc_pkg::S_CST);
      rsp_load  = 1'b0;
      norm_we   = 1'b0;
      rsp_in    = rsp_ff;
      if (state_ff == cimlc_pkg::S_END && last_ff && rsp_free && !(query_ff && held)) begin
         rsp_load = 1'b1;
         rsp_in.similarity = '0;
         rsp_in.item_index = '0;
         rsp_in.items_held = 5'(count_ff);
         if (query_ff) begin
            rsp_in.status = cimlc_pkg::ST_EMPTY;
         end else if (has_room) begin
            norm_we = 1'b1;
            rsp_in.status     = cimlc_pkg::ST_STORED;
            rsp_in.item_index = 4'(count_ff);
            rsp_in.items_held = 5'(count_ff + CNT_W'(1));
         end else begin
            rsp_in.status = cimlc_pkg::ST_FULL;
         end
      end else if (state_ff == cimlc_pkg::S_RES && rsp_free) begin
         rsp_load = 1'b1;
         rsp_in.status     = cimlc_pkg::ST_MATCH;
         rsp_in.item_index = 4'(best_idx_ff);
         rsp_in.similarity = best_sim_ff;
         rsp_in.items_held = 5'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cimlc_pkg::S_IDLE;
         vl_ff        <= cimlc_pkg::VLEN_RESET;
         pos_ff       <= '0;
         count_ff     <= '0;
         query_ff     <= cimlc_pkg::OP_STORE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) vl_ff <= csr_pwdata[cimlc_pkg::VLEN_W-1:0];
         if (accept && pos_ff == '0) query_ff <= (req_data.opcode == cimlc_pkg::OP_QUERY);
         if (state_ff == cimlc_pkg::S_END) begin
            pos_ff <= last_ff ? '0 : POS_W'(pos_plus);
         end
         if (norm_we) count_ff <= count_ff + CNT_W'(1);
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= x_in;
         sq_ff    <= x_in * x_in;
         first_ff <= (pos_ff == '0);
         last_ff  <= pos_plus >= len_eff;
      end
      if (state_ff == cimlc_pkg::S_NORM) begin
         slot_ff <= '0;
         if (query_ff) qnorm_ff <= (first_ff ? '0 : qnorm_ff) + sq_ext;
         else          nacc_ff  <= (first_ff ? '0 : nacc_ff) + sq_ext;
      end
      if (state_ff == cimlc_pkg::S_MUL) prod_ff <= rd_elem_ff * x_ff;
      if (state_ff == cimlc_pkg::S_ACC) slot_ff <= slot_ff + SLOT_W'(1);
      if (state_ff == cimlc_pkg::S_END) slot_ff <= '0;
      // keep the best cosine, lowest slot on ties
      if (state_ff == cimlc_pkg::S_CWT && cos_done) begin
         slot_ff <= slot_ff + SLOT_W'(1);
         if (slot_ff == '0 || cos_sim > best_sim_ff) begin
            best_sim_ff <= cos_sim;
            best_idx_ff <= slot_ff;
         end
      end
      if (rsp_load) rsp_ff <= rsp_in;
   end

   // element memory
   always_ff @(posedge clock) begin
      if (st_we) store_mem[addr] <= x_ff;
      if (st_re) rd_elem_ff <= store_mem[addr];
   end

   // dot accumulator memory
   always_ff @(posedge clock) begin
      if (dot_we) dot_mem[slot_ff] <= dot_new;
      if (dot_re) rd_dot_ff <= dot_mem[slot_ff];
   end

   // squared norm memory
   always_ff @(posedge clock) begin
      if (norm_we) norm_mem[count_ff[SLOT_W-1:0]] <= nacc_ff;
      if (norm_re) rd_norm_ff <= norm_mem[slot_ff];
   end

   cimlc_cosine #(
      .ACC_W (ACC_W)
   ) u_cosine (
      .clock (clock),
      .reset (reset),
      .start (cos_start),
      .dot   (rd_dot_ff),
      .na    (ACC_W'($unsigned(rd_norm_ff))),
      .nq    (ACC_W'($unsigned(qnorm_ff))),
      .done  (cos_done),
      .sim   (cos_sim)
   );

   `CIM_ASSERT(a_count_cap, clock, reset, count_ff <= CNT_W'(CAPACITY), "item count above capacity")
   `CIM_ASSERT(a_slot_held, clock, reset, (state_ff == cimlc_pkg::S_RD || state_ff == cimlc_pkg::S_CRD) |-> (CNT_W'(slot_ff) < count_ff), "slot beyond held items")
   `CIM_ASSERT(a_store_count, clock, reset, (rsp_load && rsp_in.status == cimlc_pkg::ST_STORED) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "store did not advance count")
   `CIM_ASSERT_NEVER(a_rsp_overwrite, clock, reset, rsp_load && rsp_valid_ff && !rsp_ready, "pending result overwritten")

endmodule
